FILE: rtl/lwd_pkg.sv
// Package for the latch-up watchdog supervisor.
// Holds the request and result types, register indexes and constants.
// Depends on nothing.
package lwd_pkg;

  // Width of the tick counter
  localparam int CountWidth = 16;
  // Width used to compare the counter against the 16-bit timeout
  localparam int CmpWidth   = (CountWidth > 16) ? CountWidth : 16;

  localparam logic [15:0] TimeoutReset = 16'd4000;
  localparam logic [15:0] PulseReset   = 16'd15625;
  localparam logic [7:0]  PinsReset    = 8'hFF;

  localparam logic [7:0] AliveByte   = 8'h47;  // 'G'
  localparam logic [7:0] PinCmdFirst = 8'h31;  // '1'
  localparam logic [7:0] PinCmdLast  = 8'h38;  // '8'

  localparam logic OpTick = 1'b0;
  localparam logic OpByte = 1'b1;

  localparam logic [1:0] RegTimeout = 2'd0;
  localparam logic [1:0] RegPulse   = 2'd1;
  localparam logic [1:0] RegPins    = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } lwd_in_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [7:0] pin_levels;
    logic       reset_active;
    logic       byte_dropped;
  } lwd_out_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] pulse_ticks;
  } lwd_cfg_t;

endpackage

FILE: rtl/lwd_core.sv
// Watchdog state and per-request update for the latch-up supervisor.
// Depends on lwd_pkg.
module lwd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  lwd_pkg::lwd_in_t  item,
  input  lwd_pkg::lwd_cfg_t cfg,
  output lwd_pkg::lwd_out_t result
);

  logic [lwd_pkg::CountWidth-1:0] tick_count, tick_count_next, tick_inc;
  logic [15:0] pulse_left, pulse_left_next, pulse_dec, limit, pulse_load;
  logic [7:0]  port_levels, port_levels_next;
  logic        in_pulse, in_pulse_next;
  logic        echo_valid, dropped;
  logic [7:0]  echo_byte;
  logic [2:0]  pin_sel;

  assign tick_inc   = tick_count + 1'b1;
  assign pulse_dec  = pulse_left - 16'd1;
  assign limit      = (cfg.timeout_ticks != 16'd0) ? cfg.timeout_ticks : 16'd1;
  assign pulse_load = (cfg.pulse_ticks != 16'd0) ? cfg.pulse_ticks : 16'd1;
  // '1' selects pin 7, '8' selects pin 0
  assign pin_sel    = 3'd7 - item.rx_byte[2:0] + 3'd1;

  always_comb begin
    tick_count_next  = tick_count;
    pulse_left_next  = pulse_left;
    port_levels_next = port_levels;
    in_pulse_next    = in_pulse;
    echo_valid       = 1'b0;
    echo_byte        = 8'd0;
    dropped          = 1'b0;
    if (item.op == lwd_pkg::OpTick) begin
      if (in_pulse) begin
        pulse_left_next = pulse_dec;
        tick_count_next = '0;
        if (pulse_dec == 16'd0) begin
          port_levels_next = port_levels | 8'h03;
          in_pulse_next    = 1'b0;
        end
      end else begin
        tick_count_next = tick_inc;
        if (lwd_pkg::CmpWidth'(tick_inc) >= lwd_pkg::CmpWidth'(limit)) begin
          port_levels_next = port_levels & 8'hFC;
          in_pulse_next    = 1'b1;
          pulse_left_next  = pulse_load;
          tick_count_next  = '0;
        end
      end
    end else begin
      if (in_pulse) begin
        dropped = 1'b1;
      end else begin
        if (item.rx_byte == lwd_pkg::AliveByte) begin
          tick_count_next = '0;
        end
        if (item.rx_byte >= lwd_pkg::PinCmdFirst && item.rx_byte <= lwd_pkg::PinCmdLast) begin
          port_levels_next[pin_sel] = ~port_levels[pin_sel];
        end
        echo_valid = 1'b1;
        echo_byte  = item.rx_byte;
      end
    end
  end

  assign result.echo_valid   = echo_valid;
  assign result.echo_byte    = echo_byte;
  assign result.pin_levels   = port_levels_next;
  assign result.reset_active = in_pulse_next;
  assign result.byte_dropped = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      pulse_left  <= 16'd0;
      port_levels <= lwd_pkg::PinsReset;
      in_pulse    <= 1'b0;
    end else if (step) begin
      tick_count  <= tick_count_next;
      pulse_left  <= pulse_left_next;
      port_levels <= port_levels_next;
      in_pulse    <= in_pulse_next;
    end
  end

endmodule

FILE: rtl/latchup_watchdog_supervisor.sv
// Top level of the latch-up watchdog supervisor: handshakes, registers, result register.
// Depends on lwd_pkg and lwd_core.
//
//  channel  signals                              direction  handshake
//  in       in_valid, in_stall, in_data          request in valid / stall
//  out      out_valid, out_stall, out_data       result out valid / stall
//  cfg      cfg_valid, cfg_ready, cfg_index/data write in  valid / ready
//
// One request per clock while in_stall is low: the watchdog state and the result
// register both load at the edge that accepts a request, so its result is offered
// from the next cycle on. The result register is the only storage between the two
// sides; in_stall is raised only while that register is full and the output is stalled.
// Reset (rst, synchronous): counter and pulse cleared, all pins high,
// registers back to their reset values. cfg_ready is always high.

module latchup_watchdog_supervisor (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lwd_pkg::lwd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lwd_pkg::lwd_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  lwd_pkg::lwd_cfg_t cfg;
  lwd_pkg::lwd_out_t result;
  logic              accept;

  // Hold the request while a finished result is still waiting downstream
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Register file. initial_pins only matters at reset, and reset restores it to
  // all high before the pins load, so a write to it is taken and has no effect.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= lwd_pkg::TimeoutReset;
      cfg.pulse_ticks   <= lwd_pkg::PulseReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lwd_pkg::RegTimeout: cfg.timeout_ticks <= cfg_data;
        lwd_pkg::RegPulse:   cfg.pulse_ticks   <= cfg_data;
        lwd_pkg::RegPins:    ;
        default:             ;
      endcase
    end
  end

  lwd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

FILE: tb/latchup_watchdog_supervisor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the latch-up watchdog supervisor: directed and random requests
// against a cycle-free prediction of tick counter, reset pulse and pin levels.
// Depends on lwd_pkg and the latchup_watchdog_supervisor RTL.
module latchup_watchdog_supervisor_tb;

  // Index outside the register list, to exercise the ignored write
  localparam logic [1:0] RegUnused = 2'd3;

  // Predicts the watchdog state per request and holds the results still owed by the block
  class pin_state_tracker_t;
    logic [15:0]                    timeout_ticks;
    logic [15:0]                    pulse_ticks;
    logic [7:0]                     initial_pins;
    logic [lwd_pkg::CountWidth-1:0] tick_count;
    logic [15:0]                    pulse_left;
    logic [7:0]                     port_levels;
    logic                           in_pulse;
    lwd_pkg::lwd_out_t              owed_results[$];
    int unsigned                    failures;
    int unsigned                    results_seen;

    function void reset_state();
      timeout_ticks = lwd_pkg::TimeoutReset;
      pulse_ticks   = lwd_pkg::PulseReset;
      initial_pins  = lwd_pkg::PinsReset;
      tick_count    = '0;
      pulse_left    = '0;
      port_levels   = initial_pins;
      in_pulse      = 1'b0;
      owed_results.delete();
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        lwd_pkg::RegTimeout: timeout_ticks = data;
        lwd_pkg::RegPulse:   pulse_ticks = data;
        lwd_pkg::RegPins:    initial_pins = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_request(lwd_pkg::lwd_in_t req);
      lwd_pkg::lwd_out_t            res;
      logic [lwd_pkg::CmpWidth-1:0] count_ext;
      logic [lwd_pkg::CmpWidth-1:0] limit_ext;
      logic [2:0]                   pin;
      res = '0;
      if (req.op == lwd_pkg::OpTick) begin
        if (in_pulse) begin
          pulse_left = pulse_left - 16'd1;
          tick_count = '0;
          if (pulse_left == 16'd0) begin
            port_levels = port_levels | 8'h03;
            in_pulse    = 1'b0;
          end
        end else begin
          tick_count = tick_count + 1'b1;
          count_ext  = tick_count;
          limit_ext  = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
          if (count_ext >= limit_ext) begin
            port_levels = port_levels & 8'hFC;
            in_pulse    = 1'b1;
            pulse_left  = (pulse_ticks == 16'd0) ? 16'd1 : pulse_ticks;
            tick_count  = '0;
          end
        end
      end else if (in_pulse) begin
        res.byte_dropped = 1'b1;
      end else begin
        if (req.rx_byte == lwd_pkg::AliveByte) tick_count = '0;
        if (req.rx_byte >= lwd_pkg::PinCmdFirst && req.rx_byte <= lwd_pkg::PinCmdLast) begin
          pin = 3'd7 - 3'(req.rx_byte - lwd_pkg::PinCmdFirst);
          port_levels[pin] = ~port_levels[pin];
        end
        res.echo_valid = 1'b1;
        res.echo_byte  = req.rx_byte;
      end
      res.pin_levels   = port_levels;
      res.reset_active = in_pulse;
      owed_results.push_back(res);
    endfunction

    function void check_result(lwd_pkg::lwd_out_t got);
      lwd_pkg::lwd_out_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d arrived with no request outstanding: %p", results_seen, got);
        return;
      end
      want = owed_results.pop_front();
      if (got.echo_valid !== want.echo_valid || got.echo_byte !== want.echo_byte ||
          got.pin_levels !== want.pin_levels || got.reset_active !== want.reset_active ||
          got.byte_dropped !== want.byte_dropped) begin
        failures++;
        if (failures <= 10)
          $display({"result %0d mismatch: expected echo %b/%h pins %h pulse %b dropped %b,",
                    " got echo %b/%h pins %h pulse %b dropped %b"}, results_seen,
                   want.echo_valid, want.echo_byte, want.pin_levels, want.reset_active,
                   want.byte_dropped, got.echo_valid, got.echo_byte, got.pin_levels,
                   got.reset_active, got.byte_dropped);
      end
    endfunction
  endclass

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  lwd_pkg::lwd_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  lwd_pkg::lwd_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = lwd_pkg::RegTimeout;
  logic [15:0]       cfg_data = '0;

  pin_state_tracker_t tracker;
  int unsigned        burst_left = 0;
  stall_mode_t        stall_mode = StallNone;
  int unsigned        stall_phase = 0;

  latchup_watchdog_supervisor i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock, low half first so that time zero carries no edge
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop: generous against the slowest legal run of ~1200 requests
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver back-pressure: switch at random between a handful of stall patterns, so
  // that some stretches stall never, some rarely, some mostly, some on a beat.
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
      stall_phase <= $urandom_range(20, 80);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 9) < 7);
      default:    out_stall <= (stall_phase % 3 == 0);
    endcase
  end

  // Result monitor: every accepted result is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(out_data);
  end

  function automatic lwd_pkg::lwd_in_t tick_request(logic [7:0] junk);
    lwd_pkg::lwd_in_t req;
    req.op      = lwd_pkg::OpTick;
    req.rx_byte = junk;  // ignored by the block, randomised to toggle the bits anyway
    return req;
  endfunction

  function automatic lwd_pkg::lwd_in_t byte_request(logic [7:0] value);
    lwd_pkg::lwd_in_t req;
    req.op      = lwd_pkg::OpByte;
    req.rx_byte = value;
    return req;
  endfunction

  // Mostly ticks, a phase-dependent share of alive bytes, then pin commands and noise
  function automatic lwd_pkg::lwd_in_t random_request(int unsigned alive_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return tick_request(8'($urandom));
    if (roll < 55 + alive_pct) return byte_request(lwd_pkg::AliveByte);
    if (roll < 80 + alive_pct / 2)
      return byte_request(lwd_pkg::PinCmdFirst + 8'($urandom_range(0, 7)));
    return byte_request(8'($urandom));
  endfunction

  // Offer one request and hold it until accepted. Bursts of random length are separated by
  // random gaps; a quarter of bursts run straight on with no gap at all.
  task automatic send_request(input lwd_pkg::lwd_in_t req);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(req);
  endtask

  // Short directed sequences: '.' stands for a tick, any other character is sent as a byte
  task automatic send_script(input string script);
    for (int i = 0; i < script.len(); i++) begin
      if (script[i] == ".") send_request(tick_request(8'($urandom)));
      else send_request(byte_request(script[i]));
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Hold a register write until the port takes it; the caller drops cfg_valid afterwards
  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_register(idx, data);
  endtask

  // Write all registers, plus one write to the unused index that must change nothing.
  // The pin register only matters at reset, which never comes again, so its write is inert.
  task automatic configure(input logic [15:0] timeout, input logic [15:0] pulse,
                           input logic [7:0] pins);
    write_register(lwd_pkg::RegTimeout, timeout);
    write_register(lwd_pkg::RegPulse, pulse);
    write_register(lwd_pkg::RegPins, {8'($urandom), pins});
    write_register(RegUnused, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly ticks with the odd non-alive byte mixed in
  task automatic send_ticks_and_noise(input int unsigned count);
    lwd_pkg::lwd_in_t req;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) begin
        req = byte_request(8'($urandom));
        if (req.rx_byte == lwd_pkg::AliveByte) req.rx_byte = lwd_pkg::PinCmdLast;
        send_request(req);
      end else begin
        send_request(tick_request(8'($urandom)));
      end
    end
  endtask

  initial begin
    int unsigned ticks_sent;
    logic [15:0] timeout;
    logic [15:0] pulse;
    tracker = new();
    tracker.reset_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset values first: all pins high, long timeout; extremes of the byte field, an
    // alive byte and a pin command on top of the reset state.
    send_request(byte_request(8'h00));
    send_request(byte_request(8'hFF));
    send_script(".G1.");
    drain_results();

    // Short timeout and pulse: walk every pin command, clear the counter with alive bytes,
    // let the timeout fire, drop bytes during the pulse and let the pulse run out.
    configure(16'd3, 16'd2, 8'h5A);
    send_script("2345678G..G...AG..1");

    // Random phases: zero timeout and pulse (both act as one), the minimum, then small
    // random settings so that pulses start and end often.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin timeout = 16'd0; pulse = 16'd0; end
        1:       begin timeout = 16'd1; pulse = 16'd1; end
        default: begin
          timeout = $urandom_range(1, 30);
          pulse   = $urandom_range(0, 12);
        end
      endcase
      drain_results();
      configure(timeout, pulse, 8'($urandom));
      ticks_sent = $urandom_range(0, 20);  // alive-byte share for this phase
      repeat (180) send_request(random_request(ticks_sent));
    end

    // Largest timeout: the counter climbs far from the limit and never fires.
    drain_results();
    configure(16'hFFFF, 16'hFFFF, 8'($urandom));
    send_ticks_and_noise(40);

    // Largest pulse: the first tick fires and pins 1:0 stay low, bytes are dropped.
    drain_results();
    configure(16'd1, 16'hFFFF, 8'($urandom));
    send_ticks_and_noise(40);

    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.failures == 0 && tracker.owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lwd_pkg.sv
rtl/lwd_core.sv
rtl/latchup_watchdog_supervisor.sv
tb/latchup_watchdog_supervisor_tb.sv
